// ===== hdl/idq_pkg.sv =====
// shared codes, types and default sizes of the indexed deque store
package idq_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD_HEAD    = 3'd0,
    OP_ADD_TAIL    = 3'd1,
    OP_REMOVE_HEAD = 3'd2,
    OP_REMOVE_TAIL = 3'd3,
    OP_INSERT_AT   = 3'd4,
    OP_DELETE_AT   = 3'd5,
    OP_READ_FWD    = 3'd6,
    OP_READ_REV    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ===== hdl/indexed_deque_store.sv =====
// top level of the indexed deque store: sequencer, ring addressing and result register
//
// A bounded ordered list of signed values held in a ring buffer. One input beat
// (operation, position, value) is taken when in_valid and in_ready are high;
// in_ready is high only while the sequencer is idle, also while a result waits.
// Every add, remove, insert or delete gives one result beat with out_last set.
// A read-out gives one beat per element, head to tail or tail to head, with
// out_last on the final one; an empty list gives a single beat with status empty.
// Insert and delete shift the shorter side of the list one element per cycle
// through the single read and single write port of the element memory, so an
// insert moves m = min(pos, size - pos) elements and a delete moves
// m = min(pos, size - 1 - pos), at most CAPACITY/2. Adds and removes at
// either end move nothing. A read-out gives one beat per cycle while the
// receiver is ready, each element read ahead through the registered memory
// read port.
// Reset clears the size, ring head and control state; the element memory is not
// cleared. When the receiver stalls, the result register holds its beat and the
// sequencer waits before loading the next one.
module indexed_deque_store #(
  parameter int CAPACITY   = idq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  idq_pkg::op_t        in_operation,
  input  logic [5:0]          in_position,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output idq_pkg::status_t    out_status,
  output logic signed [31:0]  out_element,
  output logic [5:0]          out_list_size,
  output logic                out_last
);
  import idq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [7:0] CAP8 = 8'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RCAP  = 6'b000010,
    S_MOVE  = 6'b000100,
    S_FIN   = 6'b001000,
    S_RES   = 6'b010000,
    S_RDOUT = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [CW-1:0]           moves_r, moves_nxt;
  logic                    asc_r, asc_nxt;
  logic                    ins_r, ins_nxt;
  logic                    front_r, front_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]           wr_addr_r, wr_addr_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic signed [31:0]      res_elem_r, res_elem_nxt;
  logic [5:0]              res_size_r, res_size_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [31:0]      out_element_r, out_element_nxt;
  logic [5:0]              out_list_size_r, out_list_size_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_wa, ram_ra;
  logic [DATA_WIDTH-1:0]   ram_wd;
  logic signed [DATA_WIDTH-1:0] rdata;
  logic [AW-1:0]           rd_log, wr_log;

  logic [7:0]              cnt8, ins_pos, del_pos;
  logic signed [DATA_WIDTH-1:0] val_fit;
  logic                    out_free;

  // logical index to ring slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, l};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] h);
    return (h == '0) ? AW'(CAPACITY - 1) : h - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] h);
    return (h == AW'(CAPACITY - 1)) ? '0 : h + AW'(1);
  endfunction

  idq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (rdata)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_element   = out_element_r;
  assign out_list_size = out_list_size_r;
  assign out_last      = out_last_r;

  assign cnt8     = 8'(count_r);
  assign val_fit  = DATA_WIDTH'(in_value);
  assign out_free = !out_valid_r || out_ready;
  assign ram_ra   = phys(head_r, rd_log);

  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    count_nxt         = count_r;
    pos_nxt           = pos_r;
    val_nxt           = val_r;
    src_nxt           = src_r;
    moves_nxt         = moves_r;
    asc_nxt           = asc_r;
    ins_nxt           = ins_r;
    front_nxt         = front_r;
    wr_pend_nxt       = wr_pend_r;
    wr_addr_nxt       = wr_addr_r;
    res_status_nxt    = res_status_r;
    res_elem_nxt      = res_elem_r;
    res_size_nxt      = res_size_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_element_nxt   = out_element_r;
    out_list_size_nxt = out_list_size_r;
    out_last_nxt      = out_last_r;
    ram_we            = 1'b0;
    ram_wa            = wr_addr_r;
    ram_wd            = rdata;
    ram_re            = 1'b0;
    rd_log            = src_r;
    wr_log            = pos_r;
    ins_pos           = 8'(in_position);
    del_pos           = 8'(in_position);

    case (in_operation)
      OP_ADD_HEAD:    ins_pos = '0;
      OP_ADD_TAIL:    ins_pos = cnt8;
      default:        ins_pos = 8'(in_position);
    endcase
    case (in_operation)
      OP_REMOVE_HEAD: del_pos = '0;
      OP_REMOVE_TAIL: del_pos = (cnt8 == '0) ? '0 : cnt8 - 8'd1;
      default:        del_pos = 8'(in_position);
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt      = val_fit;
          res_size_nxt = 6'(count_r);
          if (in_operation inside {OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT_AT}) begin
            res_elem_nxt = 32'(val_fit);
            if (ins_pos > cnt8) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RES;
            end else if (cnt8 >= CAP8) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RES;
            end else begin
              res_status_nxt = ST_OK;
              pos_nxt        = AW'(ins_pos);
              ins_nxt        = 1'b1;
              wr_pend_nxt    = 1'b0;
              state_nxt      = S_MOVE;
              if ((ins_pos << 1) < cnt8) begin
                // front side is shorter: open a slot before the head
                front_nxt = 1'b1;
                head_nxt  = ring_dec(head_r);
                src_nxt   = AW'(1);
                asc_nxt   = 1'b1;
                moves_nxt = CW'(ins_pos);
              end else begin
                front_nxt = 1'b0;
                src_nxt   = AW'(cnt8 - 8'd1);
                asc_nxt   = 1'b0;
                moves_nxt = CW'(cnt8 - ins_pos);
              end
            end
          end else if (in_operation inside {OP_REMOVE_HEAD, OP_REMOVE_TAIL, OP_DELETE_AT}) begin
            res_elem_nxt = '0;
            if (cnt8 == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_RES;
            end else if (del_pos >= cnt8) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RES;
            end else begin
              res_status_nxt = ST_OK;
              pos_nxt        = AW'(del_pos);
              ins_nxt        = 1'b0;
              wr_pend_nxt    = 1'b0;
              ram_re         = 1'b1;
              rd_log         = AW'(del_pos);
              state_nxt      = S_RCAP;
              if (((del_pos << 1) + 8'd1) < cnt8) begin
                front_nxt = 1'b1;
                src_nxt   = AW'(del_pos - 8'd1);
                asc_nxt   = 1'b0;
                moves_nxt = CW'(del_pos);
              end else begin
                front_nxt = 1'b0;
                src_nxt   = AW'(del_pos + 8'd1);
                asc_nxt   = 1'b1;
                moves_nxt = CW'(cnt8 - 8'd1 - del_pos);
              end
            end
          end else begin
            if (cnt8 == '0) begin
              res_status_nxt = ST_EMPTY;
              res_elem_nxt   = '0;
              state_nxt      = S_RES;
            end else begin
              asc_nxt   = (in_operation == OP_READ_FWD);
              ram_re    = 1'b1;
              moves_nxt = CW'(cnt8 - 8'd1);
              state_nxt = S_RDOUT;
              if (in_operation == OP_READ_FWD) begin
                rd_log  = '0;
                src_nxt = AW'(1);
              end else begin
                rd_log  = AW'(cnt8 - 8'd1);
                src_nxt = AW'(cnt8 - 8'd2);
              end
            end
          end
        end
      end

      S_RCAP: begin
        res_elem_nxt = 32'(rdata);
        state_nxt    = S_MOVE;
      end

      S_MOVE: begin
        // write back the element read last cycle while reading the next one
        if (wr_pend_r) begin
          ram_we = 1'b1;
          ram_wa = wr_addr_r;
          ram_wd = rdata;
        end
        if (moves_r != '0) begin
          ram_re      = 1'b1;
          rd_log      = src_r;
          wr_addr_nxt = phys(head_r, asc_r ? src_r - AW'(1) : src_r + AW'(1));
          wr_pend_nxt = 1'b1;
          src_nxt     = asc_r ? src_r + AW'(1) : src_r - AW'(1);
          moves_nxt   = moves_r - CW'(1);
        end else begin
          wr_pend_nxt = 1'b0;
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        wr_log = pos_r;
        if (ins_r) begin
          ram_we       = 1'b1;
          ram_wa       = phys(head_r, wr_log);
          ram_wd       = val_r;
          count_nxt    = count_r + CW'(1);
          res_size_nxt = 6'(count_r + CW'(1));
        end else begin
          count_nxt    = count_r - CW'(1);
          res_size_nxt = 6'(count_r - CW'(1));
          if (front_r) begin
            head_nxt = ring_inc(head_r);
          end
        end
        state_nxt = S_RES;
      end

      S_RES: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = res_status_r;
          out_element_nxt   = res_elem_r;
          out_list_size_nxt = res_size_r;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      S_RDOUT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ST_OK;
          out_element_nxt   = 32'(rdata);
          out_list_size_nxt = 6'(count_r);
          out_last_nxt      = (moves_r == '0);
          if (moves_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            rd_log    = src_r;
            src_nxt   = asc_r ? src_r + AW'(1) : src_r - AW'(1);
            moves_nxt = moves_r - CW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r           <= pos_nxt;
    val_r           <= val_nxt;
    src_r           <= src_nxt;
    moves_r         <= moves_nxt;
    asc_r           <= asc_nxt;
    ins_r           <= ins_nxt;
    front_r         <= front_nxt;
    wr_addr_r       <= wr_addr_nxt;
    res_status_r    <= res_status_nxt;
    res_elem_r      <= res_elem_nxt;
    res_size_r      <= res_size_nxt;
    out_status_r    <= out_status_nxt;
    out_element_r   <= out_element_nxt;
    out_list_size_r <= out_list_size_nxt;
    out_last_r      <= out_last_nxt;
  end

endmodule

// ===== hdl/idq_ram.sv =====
// element storage: one write port, one registered read port
module idq_ram #(
  parameter int DEPTH = idq_pkg::CAPACITY_DEF,
  parameter int WIDTH = idq_pkg::DATA_WIDTH_DEF,
  parameter int AW    = $clog2(idq_pkg::CAPACITY_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);
  import idq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule
